>>> src/ipid_pkg.sv
// Shared types, constants and helper functions of the incremental PID regulator.
// Holds the microcode program, the control word layout and the Q16.16 arithmetic helpers.
// Depends on nothing; every other file of the block uses it by scoped names.
package ipid_pkg;

    localparam int DATA_W = 32;             // Q16.16 word
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;     // exact product
    localparam int RND_W  = PROD_W - FRAC_W; // rounded product
    localparam int SUM_W  = RND_W + 2;      // three rounded products
    localparam int WIDE_W = 52;             // headroom for gain and accumulator sums

    localparam int NUM_CFG   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_K     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_TI   = 2'd2;

    localparam logic signed [DATA_W-1:0] GAIN_K_RST   = 32'sd6554;
    localparam logic signed [DATA_W-1:0] RATIO_DT_RST = 32'sd262144;
    localparam logic signed [DATA_W-1:0] RATIO_TI_RST = 32'sd65536;

    // Program of the sequencer
    localparam int PROG_LEN = 8;
    localparam int STEP_W   = $clog2(PROG_LEN);

    // Step condition codes
    localparam logic [1:0] COND_NONE = 2'd0; // advance to next
    localparam logic [1:0] COND_IN   = 2'd1; // hold until a sample transaction
    localparam logic [1:0] COND_OUT  = 2'd2; // hold until the result register is free

    // Multiplier operand A
    localparam logic [1:0] A_K  = 2'd0;
    localparam logic [1:0] A_Q0 = 2'd1;
    localparam logic [1:0] A_Q1 = 2'd2;
    localparam logic [1:0] A_Q2 = 2'd3;

    // Multiplier operand B
    localparam logic [2:0] B_R  = 3'd0;
    localparam logic [2:0] B_S  = 3'd1;
    localparam logic [2:0] B_E  = 3'd2;
    localparam logic [2:0] B_E1 = 3'd3;
    localparam logic [2:0] B_E2 = 3'd4;

    // Increment sum operation
    localparam logic [1:0] SUM_HOLD = 2'd0;
    localparam logic [1:0] SUM_LOAD = 2'd1;
    localparam logic [1:0] SUM_ADD  = 2'd2;

    typedef struct packed {
        logic [1:0]        cond;
        logic [STEP_W-1:0] jump;
        logic              mul_en;
        logic [1:0]        sel_a;
        logic [2:0]        sel_b;
        logic              kr_ld;
        logic              q_ld;
        logic [1:0]        sum_op;
        logic              commit;
    } ctrl_t;

    // Control store: one word per step
    function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        unique case (step)
            3'd0:
            begin   // idle: keep K*r in the product register
                w.cond = COND_IN; w.jump = 3'd1;
                w.mul_en = 1'b1; w.sel_a = A_K; w.sel_b = B_R;
            end
            3'd1:
            begin
                w.jump = 3'd2; w.kr_ld = 1'b1;
                w.mul_en = 1'b1; w.sel_a = A_K; w.sel_b = B_S;
            end
            3'd2:
            begin
                w.jump = 3'd3; w.q_ld = 1'b1;
            end
            3'd3:
            begin
                w.jump = 3'd4;
                w.mul_en = 1'b1; w.sel_a = A_Q0; w.sel_b = B_E;
            end
            3'd4:
            begin
                w.jump = 3'd5; w.sum_op = SUM_LOAD;
                w.mul_en = 1'b1; w.sel_a = A_Q1; w.sel_b = B_E1;
            end
            3'd5:
            begin
                w.jump = 3'd6; w.sum_op = SUM_ADD;
                w.mul_en = 1'b1; w.sel_a = A_Q2; w.sel_b = B_E2;
            end
            3'd6:
            begin
                w.jump = 3'd7; w.sum_op = SUM_ADD;
            end
            3'd7:
            begin
                w.cond = COND_OUT; w.jump = 3'd0; w.commit = 1'b1;
            end
            default:
            begin
                w.jump = 3'd0;
            end
        endcase
        return w;
    endfunction

    // Round a Q32.32 product to Q32.16, ties toward plus infinity
    function automatic logic signed [RND_W-1:0] rnd_q16(logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(64'sd32768);
        return t[PROD_W-1:FRAC_W];
    endfunction

    // Clip a wide value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sd2147483647);
        lo = WIDE_W'(-64'sd2147483648);
        if (x > hi)
            return 32'sh7fffffff;
        else if (x < lo)
            return 32'sh80000000;
        else
            return x[DATA_W-1:0];
    endfunction

endpackage

>>> src/ipid_in_if.sv
// Sample channel of the incremental PID regulator: valid/ready plus the sample payload.
// Depends on ipid_pkg for the data width.
interface ipid_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ipid_pkg::DATA_W-1:0]      setpoint;
    logic signed [ipid_pkg::DATA_W-1:0]      measurement;
    logic                                    restart;

    modport source (output valid, output setpoint, output measurement, output restart,
                    input ready);
    modport sink   (input valid, input setpoint, input measurement, input restart,
                    output ready);
endinterface

>>> src/ipid_out_if.sv
// Result channel of the incremental PID regulator: valid/ready plus drive and clip flag.
// Depends on ipid_pkg for the data width.
interface ipid_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ipid_pkg::DATA_W-1:0]      drive;
    logic                                    saturated;

    modport source (output valid, output drive, output saturated, input ready);
    modport sink   (input valid, input drive, input saturated, output ready);
endinterface

>>> src/incremental_pid_regulator.sv
// Top level of the incremental (velocity form) PID regulator, signed Q16.16.
// Depends on ipid_pkg, ipid_in_if and ipid_out_if.
//
// Each sample transaction brings setpoint and measurement; the block returns one result
// transaction with drive = clip(acc + q0*e + q1*e1 + q2*e2) and a flag that is set when the
// clip was active. Gains are q0 = K(1+r), q1 = -K(1+2r-s), q2 = K*r, where r = Td/T0 and
// s = T0/T come from the configuration registers, so no division runs per sample. A sample
// with restart set clears the error history and accumulator before it is processed.
// Each sample runs through an eight-step program (one idle step that accepts the sample,
// seven working steps), and no new sample is taken before the program is back in its idle
// step. A small microcoded sequencer steps a single shared 32x32 multiplier through five
// products (two for the gains, three for the increment), each registered before the next
// use. The next sample is taken as soon as the sequencer is back in its idle step, even
// while the last result still waits on the output; the sequencer holds in its final step
// only if the previous result has not been taken yet. Configuration writes belong in idle
// periods.
module incremental_pid_regulator (
    input  logic                                clk,
    input  logic                                rst_n,
    ipid_in_if.sink                             samples,
    ipid_out_if.source                          results,
    input  logic                                cfg_we,
    input  logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ipid_pkg::DATA_W-1:0]         cfg_wdata
);

    localparam int DW = ipid_pkg::DATA_W;
    localparam int PW = ipid_pkg::PROD_W;
    localparam int RW = ipid_pkg::RND_W;
    localparam int SW = ipid_pkg::SUM_W;
    localparam int WW = ipid_pkg::WIDE_W;
    localparam int TW = ipid_pkg::STEP_W;

    // Configuration registers
    logic signed [DW-1:0] gain_k_reg;
    logic signed [DW-1:0] ratio_dt_reg;
    logic signed [DW-1:0] ratio_ti_reg;

    // Sequencer
    logic [TW-1:0]   step_reg;
    logic [TW-1:0]   step_next;
    ipid_pkg::ctrl_t ctrl;

    // Datapath registers
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [RW-1:0] kr_reg;
    logic signed [DW-1:0] q0_reg;
    logic signed [DW-1:0] q1_reg;
    logic signed [DW-1:0] q2_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;
    logic signed [DW-1:0] e_reg;
    logic signed [DW-1:0] e1_reg;
    logic signed [DW-1:0] e2_reg;
    logic signed [DW-1:0] acc_reg;

    // Result register
    logic                 out_valid_reg;
    logic signed [DW-1:0] drive_reg;
    logic                 sat_reg;

    logic                 in_fire;
    logic                 out_free;
    logic                 do_commit;
    logic signed [DW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic signed [RW-1:0] prod_rnd;
    logic signed [WW-1:0] err_wide;
    logic signed [WW-1:0] q0_wide;
    logic signed [WW-1:0] q1_wide;
    logic signed [WW-1:0] acc_wide;
    logic signed [DW-1:0] acc_clip;
    logic                 acc_hit;

    assign ctrl = ipid_pkg::ucode(step_reg);

    // Ready only in the idle step
    assign samples.ready = (ctrl.cond == ipid_pkg::COND_IN);
    assign in_fire       = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign do_commit     = ctrl.commit && out_free;

    assign results.valid     = out_valid_reg;
    assign results.drive     = drive_reg;
    assign results.saturated = sat_reg;

    // Step counter with conditional holds
    always_comb
    begin
        step_next = ctrl.jump;
        unique case (ctrl.cond)
            ipid_pkg::COND_IN:
            begin
                if (!in_fire)
                    step_next = step_reg;
            end
            ipid_pkg::COND_OUT:
            begin
                if (!out_free)
                    step_next = step_reg;
            end
            default:
            begin
                step_next = ctrl.jump;
            end
        endcase
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        unique case (ctrl.sel_a)
            ipid_pkg::A_Q0: mul_a = q0_reg;
            ipid_pkg::A_Q1: mul_a = q1_reg;
            ipid_pkg::A_Q2: mul_a = q2_reg;
            default:        mul_a = gain_k_reg;
        endcase
        unique case (ctrl.sel_b)
            ipid_pkg::B_S:  mul_b = ratio_ti_reg;
            ipid_pkg::B_E:  mul_b = e_reg;
            ipid_pkg::B_E1: mul_b = e1_reg;
            ipid_pkg::B_E2: mul_b = e2_reg;
            default:        mul_b = ratio_dt_reg;
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);
    assign prod_rnd  = ipid_pkg::rnd_q16(prod_reg);

    // Gains: q0 = K + kr, q1 = -(K + 2kr - ks), with ks the product now in prod_reg
    assign q0_wide = WW'(gain_k_reg) + WW'(kr_reg);
    assign q1_wide = WW'(0) - (WW'(gain_k_reg) + (WW'(kr_reg) <<< 1) - WW'(prod_rnd));

    // Increment accumulation
    always_comb
    begin
        case (ctrl.sum_op)
            ipid_pkg::SUM_LOAD: sum_next = SW'(prod_rnd);
            ipid_pkg::SUM_ADD:  sum_next = sum_reg + SW'(prod_rnd);
            default:            sum_next = sum_reg;
        endcase
    end

    // Error with clipping
    assign err_wide = WW'(samples.setpoint) - WW'(samples.measurement);

    // Accumulator update and clip detection
    assign acc_wide = WW'(acc_reg) + WW'(sum_reg);
    assign acc_clip = ipid_pkg::sat32(acc_wide);
    assign acc_hit  = (acc_wide != WW'(acc_clip));

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            gain_k_reg    <= ipid_pkg::GAIN_K_RST;
            ratio_dt_reg  <= ipid_pkg::RATIO_DT_RST;
            ratio_ti_reg  <= ipid_pkg::RATIO_TI_RST;
            e1_reg        <= '0;
            e2_reg        <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            step_reg <= step_next;

            if (do_commit)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;

            // Drop writes beyond the register list
            if (cfg_we)
            begin
                case (cfg_index)
                    ipid_pkg::CFG_GAIN_K:   gain_k_reg   <= cfg_wdata;
                    ipid_pkg::CFG_RATIO_DT: ratio_dt_reg <= cfg_wdata;
                    ipid_pkg::CFG_RATIO_TI: ratio_ti_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end

            // History and accumulator: clear on restart, advance on commit
            if (in_fire && samples.restart)
            begin
                e1_reg  <= '0;
                e2_reg  <= '0;
                acc_reg <= '0;
            end
            else if (do_commit)
            begin
                e2_reg  <= e1_reg;
                e1_reg  <= e_reg;
                acc_reg <= acc_clip;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= prod_next;
        if (ctrl.kr_ld)
            kr_reg <= prod_rnd;
        if (ctrl.q_ld)
        begin
            q0_reg <= ipid_pkg::sat32(q0_wide);
            q1_reg <= ipid_pkg::sat32(q1_wide);
            q2_reg <= ipid_pkg::sat32(WW'(kr_reg));
        end
        sum_reg <= sum_next;
        if (in_fire)
            e_reg <= ipid_pkg::sat32(err_wide);
        if (do_commit)
        begin
            drive_reg <= acc_clip;
            sat_reg   <= acc_hit;
        end
    end

endmodule
